@@ rtl/pure_pursuit_steering_defines.svh @@
// Assertion macros shared by the pure pursuit steering block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PURE_PURSUIT_STEERING_DEFINES_SVH
`define PURE_PURSUIT_STEERING_DEFINES_SVH

`ifndef SYNTHESIS
`define PPST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pure pursuit steering assertion failed");
`define PPST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pure pursuit steering assertion failed");
`else
`define PPST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/ppst_pkg.sv @@
// Shared types, constants and tables of the pure pursuit steering block.
// No dependencies; imported by every module of the block.
package ppst_pkg;

    localparam int ANGLE_ITERATIONS = 16;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [25:0] HALF_TURN_24 = 26'd8388608;

    localparam int DIST_W = 33;
    localparam int NUM_W  = 52;
    localparam int DEN_W  = DIST_W + 13;
    localparam int Q_W    = 32;

    localparam logic [21:0] ATAN_TAB [0:31] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81,
        22'd41,      22'd20,      22'd10,     22'd5,
        22'd3,       22'd1,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef enum logic [1:0] {
        MODE_FAST    = 2'd0,
        MODE_SLOW    = 2'd1,
        MODE_PURSUIT = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_FAST_THR  = 3'd0,
        CFG_SLOW_THR  = 3'd1,
        CFG_FAST_RATE = 3'd2,
        CFG_SLOW_RATE = 3'd3,
        CFG_CRUISE    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_mode             mode;
        logic [31:0]       turn_rate;
        logic [DIST_W-1:0] goal_dist;
        logic              neg;
    } t_ctx;

endpackage

@@ rtl/pure_pursuit_steering.sv @@
// Top level of the pure pursuit steering block: registers, mode decision and output buffer.
// Depends on ppst_pkg, ppst_bearing, ppst_sine, ppst_div and the defines header.
//
// One input beat carries a robot pose and a look-ahead goal; one output beat carries the
// resulting speed and angular rate command, the steering mode and the saturation flag.
// Input tdata from bit 0: robot_x, robot_y, robot_heading, goal_x, goal_y.
// Output tdata from bit 0: linear_speed, angular_rate, steer_mode, rate_saturated, one
// zero pad bit.
// The datapath is a single pipeline of 2*ANGLE_ITERATIONS + 43 register stages, set by the
// two CORDIC units (one stage per iteration) and the divider (one quotient bit per stage).
// A beat can be taken in every cycle while the skid register is empty.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data, by the user
// only while no beat is in flight (not enforced by the block); unknown indices are ignored.
// Reset is synchronous and active low: it empties the pipeline and restores the
// register defaults. When the receiver stalls, a skid register takes one more result
// and the input side then holds o_s_tready low until the skid register drains.
`include "pure_pursuit_steering_defines.svh"

module pure_pursuit_steering import ppst_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // robot_x, robot_y, robot_heading, goal_x, goal_y
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // linear_speed, angular_rate, steer_mode, rate_saturated, zero pad
    output logic [55:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [19:0]  i_cfg_data
);

    typedef struct packed {
        logic [19:0] speed;
        logic [31:0] rate;
        t_mode       mode;
        logic        sat;
    } t_result;

    logic [15:0] r_fast_thr, r_slow_thr;
    logic [19:0] r_fast_rate, r_slow_rate, r_cruise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_thr  <= 16'd10923;
            r_slow_thr  <= 16'd3641;
            r_fast_rate <= 20'd39322;
            r_slow_rate <= 20'd16384;
            r_cruise    <= 20'd13107;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FAST_THR:  r_fast_thr  <= i_cfg_data[15:0];
                CFG_SLOW_THR:  r_slow_thr  <= i_cfg_data[15:0];
                CFG_FAST_RATE: r_fast_rate <= i_cfg_data;
                CFG_SLOW_RATE: r_slow_rate <= i_cfg_data;
                CFG_CRUISE:    r_cruise    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_skid_valid, r_out_valid;
    t_result r_skid, r_out;

    assign adv        = !r_skid_valid;
    assign o_s_tready = adv;

    // input stage: difference vector
    logic               r0_valid;
    logic signed [32:0] r0_dx, r0_dy;
    logic [15:0]        r0_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_valid <= 1'b0;
        else if (adv) r0_valid <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_dx <= 33'($signed(i_s_tdata[111:80])) - 33'($signed(i_s_tdata[31:0]));
            r0_dy <= 33'($signed(i_s_tdata[143:112])) - 33'($signed(i_s_tdata[63:32]));
            r0_heading <= i_s_tdata[79:64];
        end
    end

    logic              b_valid;
    logic [15:0]       b_bearing, b_heading;
    logic [DIST_W-1:0] b_dist;

    ppst_bearing u_bearing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (r0_valid),
        .i_dx      (r0_dx),
        .i_dy      (r0_dy),
        .i_heading (r0_heading),
        .o_valid   (b_valid),
        .o_bearing (b_bearing),
        .o_heading (b_heading),
        .o_dist    (b_dist)
    );

    // mode decision and sine argument folding
    logic [15:0]        err;
    logic [16:0]        err17;
    logic               in_fast, in_slow;
    logic signed [16:0] s_err, s_fold;
    t_ctx               n_ctx1;
    logic               r1_valid;
    logic signed [24:0] r1_angle;
    t_ctx               r1_ctx;

    always_comb begin
        err   = b_bearing - b_heading;
        err17 = {1'b0, err};
        in_fast = (err17 > {1'b0, r_fast_thr}) &&
                  (err17 < (17'h10000 - {1'b0, r_fast_thr}));
        in_slow = (err17 > {1'b0, r_slow_thr}) &&
                  (err17 < (17'h10000 - {1'b0, r_slow_thr}));
        s_err = 17'($signed(err));
        if (s_err > 17'sd16384) s_fold = 17'sd32768 - s_err;
        else if (s_err < -17'sd16384) s_fold = -17'sd32768 - s_err;
        else s_fold = s_err;
        n_ctx1.goal_dist = b_dist;
        n_ctx1.neg  = 1'b0;
        if (in_fast) begin
            n_ctx1.mode = MODE_FAST;
            n_ctx1.turn_rate = err[15] ? 32'(r_fast_rate) : 32'd0 - 32'(r_fast_rate);
        end else if (in_slow) begin
            n_ctx1.mode = MODE_SLOW;
            n_ctx1.turn_rate = err[15] ? 32'(r_slow_rate) : 32'd0 - 32'(r_slow_rate);
        end else begin
            n_ctx1.mode = MODE_PURSUIT;
            n_ctx1.turn_rate = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (adv) r1_valid <= b_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_angle <= 25'(s_fold) <<< 8;
            r1_ctx   <= n_ctx1;
        end
    end

    logic               s_valid;
    logic signed [32:0] s_sin;
    t_ctx               s_ctx;

    ppst_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r1_valid),
        .i_angle (r1_angle),
        .i_ctx   (r1_ctx),
        .o_valid (s_valid),
        .o_sin   (s_sin),
        .o_ctx   (s_ctx)
    );

    // numerator multiply
    logic [31:0]      abs_sin;
    t_ctx             n_ctx2;
    logic             r2_valid;
    logic [NUM_W-1:0] r2_num;
    logic [DEN_W-1:0] r2_den;
    t_ctx             r2_ctx;

    always_comb begin
        abs_sin = s_sin[32] ? 32'(-s_sin) : s_sin[31:0];
        n_ctx2 = s_ctx;
        n_ctx2.neg = !s_sin[32] && (s_sin != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (adv) r2_valid <= s_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_num <= NUM_W'(r_cruise) * NUM_W'(abs_sin);
            r2_den <= {s_ctx.goal_dist, 13'd0};
            r2_ctx <= n_ctx2;
        end
    end

    logic           d_valid, d_ovf;
    logic [Q_W-1:0] d_quot;
    t_ctx           d_ctx;

    ppst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r2_valid),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_ctx   (r2_ctx),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_ovf   (d_ovf),
        .o_ctx   (d_ctx)
    );

    // result assembly
    logic [31:0] lim, mag;
    t_result     n_res;

    always_comb begin
        lim = d_ctx.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        n_res.mode = d_ctx.mode;
        n_res.speed = '0;
        n_res.sat = 1'b0;
        n_res.rate = d_ctx.turn_rate;
        mag = d_quot;
        if (d_ctx.mode == MODE_PURSUIT) begin
            n_res.speed = r_cruise;
            if (d_ctx.goal_dist == '0) begin
                n_res.rate = '0;
                n_res.sat = 1'b1;
            end else begin
                if (d_ovf || (d_quot > lim)) begin
                    mag = lim;
                    n_res.sat = 1'b1;
                end
                n_res.rate = d_ctx.neg ? 32'd0 - mag : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= d_valid;
            end
        end else if (d_valid && adv) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (d_valid && adv) begin
            r_skid <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.sat, r_out.mode, r_out.rate, r_out.speed};

    `PPST_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PPST_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_m_tready, !r_skid_valid)
    `PPST_ASSERT_IMP(a_turn_no_speed, i_clk, i_rst_n,
        r_out_valid && (r_out.mode != MODE_PURSUIT), (r_out.speed == '0) && !r_out.sat)

endmodule

@@ rtl/ppst_bearing.sv @@
// Bearing and distance unit: normalisation, pipelined vectoring CORDIC and gain multiply.
// Depends on ppst_pkg.
module ppst_bearing import ppst_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [32:0]       i_dx,
    input  logic signed [32:0]       i_dy,
    input  logic [15:0]              i_heading,
    output logic                     o_valid,
    output logic [15:0]              o_bearing,
    output logic [15:0]              o_heading,
    output logic [DIST_W-1:0]        o_dist
);

    localparam int N    = ANGLE_ITERATIONS;
    localparam int CX_W = 36;
    localparam int CZ_W = 26;

    typedef struct packed {
        logic       nz;
        logic [4:0] sh;
        logic [15:0] heading;
    } t_side;

    // stage A: magnitude and leading-zero count
    logic [32:0] ax_full, ay_full;
    logic [31:0] ax, ay, m;
    logic [4:0]  n_sh;
    logic                    r_a_valid;
    logic signed [32:0]      r_a_dx, r_a_dy;
    t_side                   r_a_side;

    always_comb begin
        ax_full = i_dx[32] ? (33'd0 - i_dx) : i_dx;
        ay_full = i_dy[32] ? (33'd0 - i_dy) : i_dy;
        ax = ax_full[31:0];
        ay = ay_full[31:0];
        m = (ax > ay) ? ax : ay;
        n_sh = '0;
        for (int k = 0; k < 32; k++) begin
            if (m[k]) n_sh = 5'(31 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else if (i_en) r_a_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dx <= i_dx;
            r_a_dy <= i_dy;
            r_a_side.nz <= (i_dx != '0) || (i_dy != '0);
            r_a_side.sh <= n_sh;
            r_a_side.heading <= i_heading;
        end
    end

    // stage B: shift and fold into the right half-plane
    logic signed [32:0]      dxs, dys;
    logic                    r_cv [0:N];
    logic signed [CX_W-1:0]  r_cx [0:N];
    logic signed [CX_W-1:0]  r_cy [0:N];
    logic signed [CZ_W-1:0]  r_cz [0:N];
    t_side                   r_cs [0:N];

    assign dxs = r_a_dx <<< r_a_side.sh;
    assign dys = r_a_dy <<< r_a_side.sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv[0] <= 1'b0;
        else if (i_en) r_cv[0] <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (dxs[32]) begin
                r_cx[0] <= -CX_W'(dxs);
                r_cy[0] <= -CX_W'(dys);
                r_cz[0] <= HALF_TURN_24;
            end else begin
                r_cx[0] <= CX_W'(dxs);
                r_cy[0] <= CX_W'(dys);
                r_cz[0] <= '0;
            end
            r_cs[0] <= r_a_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[i+1] <= 1'b0;
            else if (i_en) r_cv[i+1] <= r_cv[i];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][CX_W-1]) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + CZ_W'(ATAN_TAB[i]);
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - CZ_W'(ATAN_TAB[i]);
                end
                r_cs[i+1] <= r_cs[i];
            end
        end
    end

    // stage C: rounded bearing and two partial products of the gain multiply
    logic [33:0] xc;
    logic [24:0] b_sum;
    logic        r_c_valid;
    logic [46:0] r_c_plo, r_c_phi;
    logic [15:0] r_c_bearing;
    t_side       r_c_side;

    assign xc    = r_cx[N][CX_W-1] ? 34'd0 : r_cx[N][33:0];
    assign b_sum = {1'b0, r_cz[N][23:0]} + 25'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_valid <= 1'b0;
        else if (i_en) r_c_valid <= r_cv[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_plo <= 47'(xc[16:0]) * 47'(INV_GAIN_Q30);
            r_c_phi <= 47'(xc[33:17]) * 47'(INV_GAIN_Q30);
            r_c_bearing <= b_sum[23:8];
            r_c_side <= r_cs[N];
        end
    end

    // stage D: product sum
    logic        r_d_valid;
    logic [64:0] r_d_prod;
    logic [15:0] r_d_bearing;
    t_side       r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= 1'b0;
        else if (i_en) r_d_valid <= r_c_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_prod <= 65'(r_c_plo) + (65'(r_c_phi) << 17);
            r_d_bearing <= r_c_bearing;
            r_d_side <= r_c_side;
        end
    end

    // stage E: rounding shift back to Q16.16
    logic [5:0]  rnd_sh, out_sh;
    logic [64:0] rnd_sum, dist_full;

    always_comb begin
        rnd_sh = 6'(r_d_side.sh) + 6'd29;
        out_sh = 6'(r_d_side.sh) + 6'd30;
        rnd_sum = r_d_prod + (65'd1 << rnd_sh);
        dist_full = rnd_sum >> out_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_d_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_bearing <= r_d_side.nz ? r_d_bearing : 16'd0;
            o_dist    <= r_d_side.nz ? dist_full[DIST_W-1:0] : '0;
            o_heading <= r_d_side.heading;
        end
    end

endmodule

@@ rtl/ppst_sine.sv @@
// Sine unit: pipelined rotation CORDIC giving a Q2.30 sine of a folded angle.
// Depends on ppst_pkg.
module ppst_sine import ppst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [24:0] i_angle,
    input  t_ctx               i_ctx,
    output logic               o_valid,
    output logic signed [32:0] o_sin,
    output t_ctx               o_ctx
);

    localparam int N = ANGLE_ITERATIONS;

    logic               r_v [0:N];
    logic signed [32:0] r_x [0:N];
    logic signed [32:0] r_y [0:N];
    logic signed [24:0] r_z [0:N];
    t_ctx               r_c [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= 33'(INV_GAIN_Q30);
            r_y[0] <= '0;
            r_z[0] <= i_angle;
            r_c[0] <= i_ctx;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else if (i_en) r_v[i+1] <= r_v[i];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][24]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - 25'(ATAN_TAB[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + 25'(ATAN_TAB[i]);
                end
                r_c[i+1] <= r_c[i];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_sin   = r_y[N];
    assign o_ctx   = r_c[N];

endmodule

@@ rtl/ppst_div.sv @@
// Rounding divider: pipelined restoring division, one quotient bit per stage.
// Depends on ppst_pkg.
module ppst_div import ppst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_ctx             i_ctx,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic             o_ovf,
    output t_ctx             o_ctx
);

    localparam int REM_W = NUM_W + 1;
    localparam int CMP_W = DEN_W + Q_W + 1;

    logic [REM_W-1:0] n_rem;

    logic             r_v   [0:Q_W];
    logic [REM_W-1:0] r_rem [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic             r_ovf [0:Q_W];
    t_ctx             r_c   [0:Q_W];

    // Half the divisor is added first so that the quotient rounds half up.
    assign n_rem = REM_W'(i_num) + REM_W'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= CMP_W'(n_rem) >= (CMP_W'(i_den) << Q_W);
            r_c[0]   <= i_ctx;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_bit
        logic [CMP_W-1:0] dsh;
        assign dsh = CMP_W'(r_den[k]) << (Q_W - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (i_en) r_v[k+1] <= r_v[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (CMP_W'(r_rem[k]) >= dsh) begin
                    r_rem[k+1] <= r_rem[k] - dsh[REM_W-1:0];
                    r_q[k+1]   <= r_q[k] | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
                r_c[k+1]   <= r_c[k];
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_quot  = r_q[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_ctx   = r_c[Q_W];

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the pure pursuit steering block.
// Depends on ppst_pkg and pure_pursuit_steering; a local predictor computes each command.
module tb import ppst_pkg::*;;

    typedef struct packed {
        logic [31:0] goal_y;
        logic [31:0] goal_x;
        logic [15:0] heading;
        logic [31:0] robot_y;
        logic [31:0] robot_x;
    } t_pose;

    typedef struct packed {
        logic        sat;
        t_mode       mode;
        logic [31:0] rate;
        logic [19:0] speed;
    } t_cmd;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [55:0]  o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [19:0]  i_cfg_data = '0;

    pure_pursuit_steering DUT (.*);

    always #10 i_clk = ~i_clk;

    localparam longint ATAN [0:31] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0};
    localparam longint GAIN_Q30 = 652032874;

    longint fast_thr = 10923, slow_thr = 3641, fast_rate = 39322;
    longint slow_rate = 16384, cruise = 13107;

    t_pose  pending_poses[$];
    t_cmd   expected_cmds[$];
    int     errors = 0;
    int     send_idle = 21, recv_idle = 79;
    bit     hold_off = 1'b0;
    logic   o_s_tready_q = 1'b0;
    t_cmd   got;

    function automatic longint sar(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sine_q30(longint a);
        longint s, x, y, z, nx, ny;
        s = (a >= 32768) ? a - 65536 : a;
        if (s > 16384) s = 32768 - s;
        else if (s < -16384) s = -32768 - s;
        x = GAIN_Q30; y = 0; z = s * 256;
        for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
            if (z >= 0) begin
                nx = x - sar(y, i); ny = y + sar(x, i); z -= ATAN[i];
            end else begin
                nx = x + sar(y, i); ny = y - sar(x, i); z += ATAN[i];
            end
            x = nx; y = ny;
        end
        return y;
    endfunction

    function automatic t_cmd steer_command(t_pose p);
        longint dx, dy, ax, ay, m, x, y, z, nx, ny, b24, s, mag, lim, rate;
        longint unsigned goal_dist, num, den;
        int sh;
        longint bearing, err;
        t_cmd c;
        dx = longint'($signed(p.goal_x)) - longint'($signed(p.robot_x));
        dy = longint'($signed(p.goal_y)) - longint'($signed(p.robot_y));
        bearing = 0; goal_dist = 0; c = '0;
        if (dx != 0 || dy != 0) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            sh = 0;
            while (m < 64'h8000_0000) begin
                m = m << 1; sh++;
            end
            dx = dx << sh; dy = dy << sh;
            if (dx < 0) begin
                x = -dx; y = -dy; z = 8388608;
            end else begin
                x = dx; y = dy; z = 0;
            end
            for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
                if (y >= 0) begin
                    nx = x + sar(y, i); ny = y - sar(x, i); z += ATAN[i];
                end else begin
                    nx = x - sar(y, i); ny = y + sar(x, i); z -= ATAN[i];
                end
                x = nx; y = ny;
            end
            b24 = z & 64'hFF_FFFF;
            bearing = ((b24 + 128) >> 8) & 16'hFFFF;
            if (x < 0) x = 0;
            goal_dist = (longint'(x) * GAIN_Q30 + (64'd1 << (29 + sh))) >> (30 + sh);
        end
        err = (bearing - longint'(p.heading)) & 16'hFFFF;
        if (err > fast_thr && err < 65536 - fast_thr) begin
            c.mode = MODE_FAST;
            rate = err < 32768 ? -fast_rate : fast_rate;
        end else if (err > slow_thr && err < 65536 - slow_thr) begin
            c.mode = MODE_SLOW;
            rate = err < 32768 ? -slow_rate : slow_rate;
        end else begin
            c.mode = MODE_PURSUIT;
            c.speed = cruise[19:0];
            if (goal_dist == 0) begin
                rate = 0; c.sat = 1'b1;
            end else begin
                s = sine_q30(err);
                num = cruise * (s < 0 ? -s : s);
                den = goal_dist << 13;
                mag = (num + den / 2) / den;
                lim = s > 0 ? 64'd2147483648 : 64'd2147483647;
                if (mag > lim) begin
                    mag = lim; c.sat = 1'b1;
                end
                rate = s > 0 ? -mag : mag;
            end
        end
        c.rate = rate[31:0];
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FAST_THR:  fast_thr = longint'(val[15:0]);
            CFG_SLOW_THR:  slow_thr = longint'(val[15:0]);
            CFG_FAST_RATE: fast_rate = longint'(val);
            CFG_SLOW_RATE: slow_rate = longint'(val);
            CFG_CRUISE:    cruise = longint'(val);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_poses.size() != 0 || expected_cmds.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
        endcase
    endfunction

    function automatic t_pose rnd_pose();
        t_pose p;
        p.robot_x = rnd_coord(); p.robot_y = rnd_coord();
        p.goal_x = rnd_coord(); p.goal_y = rnd_coord();
        p.heading = 16'($urandom());
        case ($urandom_range(0, 5))
            0: begin
                p.goal_x = p.robot_x; p.goal_y = p.robot_y;
            end
            1: begin
                p.goal_x = p.robot_x + $urandom_range(0, 3) - 1;
                p.goal_y = p.robot_y + $urandom_range(0, 3) - 1;
            end
            default: ;
        endcase
        return p;
    endfunction

    // The driver offers the head of the queue, holds it until the beat is taken and
    // then drops it.
    always @(negedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready_q) begin
            expected_cmds.push_back(steer_command(pending_poses.pop_front()));
        end
        if (!i_s_tvalid || (i_rst_n && o_s_tready_q)) begin
            if (pending_poses.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= pending_poses[0];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= !hold_off && $urandom_range(0, 99) >= recv_idle;
    end

    always @(posedge i_clk) begin
        o_s_tready_q <= o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[54:0];
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t unexpected command %h", $time, got);
            end else if (got != expected_cmds[0]) begin
                errors++;
                $display("%0t mismatch expected %h actual %h", $time, expected_cmds[0], got);
                void'(expected_cmds.pop_front());
            end else begin
                void'(expected_cmds.pop_front());
            end
        end
    end

    initial begin
        t_pose p;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // Directed beats: zero distance, extremes, three quadrants and all modes.
        p = '0; pending_poses.push_back(p);
        p.heading = 16'hFFFF; pending_poses.push_back(p);
        p = '0; p.goal_x = 32'h7FFF_FFFF; p.robot_x = 32'h8000_0000;
        p.goal_y = 32'h7FFF_FFFF; p.robot_y = 32'h8000_0000; pending_poses.push_back(p);
        p.goal_x = 32'h8000_0000; p.robot_x = 32'h7FFF_FFFF; pending_poses.push_back(p);
        p.heading = 16'h8000; pending_poses.push_back(p);
        p = '0; p.goal_x = 1; pending_poses.push_back(p);
        for (int h = 0; h < 65536; h += 4096) begin
            p = '0; p.goal_x = 32'h0001_0000; p.goal_y = 32'hFFFF_0000; p.heading = 16'(h);
            pending_poses.push_back(p);
        end
        p = '0; p.goal_x = 1; p.goal_y = 1; p.heading = 16'h1F00; pending_poses.push_back(p);
        wait_drained();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_FAST_THR,
                20'(ph == 1 ? 16'h8000 : ph == 2 ? 0 : $urandom_range(2000, 20000)));
            write_reg(CFG_SLOW_THR,
                20'(ph == 1 ? 16'h8000 : ph == 2 ? 0 : $urandom_range(0, 4000)));
            write_reg(CFG_FAST_RATE, 20'(ph == 3 ? 20'hFFFFF : ph == 4 ? 0 : $urandom()));
            write_reg(CFG_SLOW_RATE, 20'(ph == 3 ? 20'hFFFFF : ph == 4 ? 0 : $urandom()));
            write_reg(CFG_CRUISE, 20'(ph == 3 ? 20'hFFFFF : ph == 4 ? 0 : $urandom()));
            if (ph == 2) begin
                send_idle = 79; recv_idle = 21;
            end else if (ph == 4) begin
                send_idle = 0; recv_idle = 0;
            end
            for (int k = 0; k < 150; k++) pending_poses.push_back(rnd_pose());
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            wait_drained();
        end
        if (errors == 0 && expected_cmds.size() == 0) begin
            $display("pure_pursuit_steering regression: pass");
        end else begin
            $display("pure_pursuit_steering regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("pure_pursuit_steering regression: fail");
        $finish;
    end
endmodule
